FILE: sv/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Types, constants and helpers shared by the reflow profile sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

	// Number of profile rows the sequence walks through before it ends.
	localparam int PROFILE_ROWS = 8;

	// Profile rows held in the register file, one per configuration register.
	localparam int ROW_REGS  = 8;
	localparam int ROW_SEL_W = $clog2(ROW_REGS);
	localparam int ROW_IDX_W = 4;
	localparam int CFG_IDX_W = 4;
	localparam int ROW_W     = 33;
	localparam int TEMP_W    = 14;
	localparam int HOLD_W    = 16;
	localparam int KIND_W    = 2;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 24;

	localparam logic [ROW_IDX_W-1:0] ROW_END = ROW_IDX_W'(PROFILE_ROWS);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_UPPER  = 3'd1,
		MODE_LOWER  = 3'd2,
		MODE_BOTH   = 3'd3,
		MODE_FINISH = 3'd4,
		MODE_RSVD5  = 3'd5,
		MODE_RSVD6  = 3'd6,
		MODE_RSVD7  = 3'd7
	} mode_t;

	// One profile row, packed exactly as the configuration register.
	typedef struct packed {
		logic [HOLD_W-1:0]        hold;
		logic signed [TEMP_W-1:0] target;
		mode_t                    mode;
	} row_t;

	localparam row_t ROW_RESET = '{hold: '0, target: '0, mode: MODE_FINISH};

	// Heater drive: bit 0 upper, bit 1 lower.
	function automatic logic [1:0] mode_drive(mode_t mode);
		logic [1:0] drive;
		case (mode)
			MODE_UPPER: drive = 2'b01;
			MODE_LOWER: drive = 2'b10;
			MODE_BOTH:  drive = 2'b11;
			default:    drive = 2'b00;
		endcase
		return drive;
	endfunction

endpackage

FILE: sv/rps_row_table.sv
// ----------------------------------------------------------------------------
// rps_row_table
// Profile row registers, written through the configuration channel and read
// at the current row index.
// ----------------------------------------------------------------------------
module rps_row_table import rps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [ROW_W-1:0]     wr_data,
	input  logic [ROW_SEL_W-1:0] rd_sel,
	output row_t                 rd_row
);

	row_t rows_q [ROW_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_REGS; i++) rows_q[i] <= ROW_RESET;
		end else if (wr_en && (wr_index < CFG_IDX_W'(ROW_REGS))) begin
			rows_q[wr_index[ROW_SEL_W-1:0]] <= row_t'(wr_data);
		end
	end

	assign rd_row = rows_q[rd_sel];

endmodule

FILE: sv/rps_step_core.sv
// ----------------------------------------------------------------------------
// rps_step_core
// Sequencer state and tick decision logic, with the result register.
// ----------------------------------------------------------------------------
module rps_step_core import rps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  kind_t                item_kind,
	input  logic signed [TEMP_W-1:0] item_temp,
	output logic                 item_take,
	output logic [ROW_SEL_W-1:0] row_sel,
	input  row_t                 row,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_DATA_W-1:0]  m_axis_tdata
);

	logic [ROW_IDX_W-1:0] row_q, row_d;
	logic [HOLD_W-1:0]    hold_q, hold_d;
	logic                 done_q, done_d;
	logic [1:0]           drive_q, drive_d;
	logic                 changed;
	logic                 out_valid_q;
	logic [M_DATA_W-1:0]  out_data_q;
	logic                 below, above;

	assign item_take = item_valid && (!out_valid_q || m_axis_tready);
	assign row_sel   = row_q[ROW_SEL_W-1:0];
	assign below     = item_temp < row.target;
	assign above     = item_temp > row.target;

	always_comb begin
		row_d   = row_q;
		hold_d  = hold_q;
		done_d  = done_q;
		drive_d = drive_q;
		changed = 1'b0;
		case (item_kind)
			KIND_START: begin
				row_d  = '0;
				hold_d = '0;
				done_d = 1'b0;
			end
			KIND_STOP: begin
				row_d   = '0;
				hold_d  = '0;
				done_d  = 1'b1;
				drive_d = 2'b00;
			end
			KIND_TICK: begin
				if (!done_q) begin
					if (row_q >= ROW_END || row.mode == MODE_FINISH) begin
						done_d  = 1'b1;
						drive_d = 2'b00;
					end else if (hold_q != '0) begin
						hold_d  = hold_q - 1'b1;
						drive_d = below ? mode_drive(row.mode) : 2'b00;
						if (hold_q == HOLD_W'(1)) begin
							row_d   = row_q + 1'b1;
							changed = 1'b1;
						end
					end else if (below) begin
						drive_d = mode_drive(row.mode);
					end else if (above) begin
						if (row.hold == '0) begin
							row_d   = row_q + 1'b1;
							changed = 1'b1;
						end else begin
							hold_d = row.hold;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			hold_q  <= '0;
			done_q  <= 1'b1;
			drive_q <= 2'b00;
		end else if (item_take) begin
			row_q   <= row_d;
			hold_q  <= hold_d;
			done_q  <= done_d;
			drive_q <= drive_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			out_data_q <= {hold_d, done_d, changed, row_d, drive_d[1], drive_d[0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A beat that reports a row change leaves the index one past where it was.
	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && changed) |=> (row_q == $past(row_q) + 1'b1))
		else $error("row change without index advance");

	// A stop always lands idle with the heaters off at row zero.
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item_kind == KIND_STOP) |=>
		(done_q && drive_q == 2'b00 && row_q == '0 && hold_q == '0))
		else $error("stop did not return to idle");

	// Heaters are never driven once the run is over.
	a_off_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (drive_q == 2'b00))
		else $error("heater on while finished");

	// The index never runs beyond the end-of-table marker.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_END)
		else $error("row index past table end");

	// A held result is not overwritten while the receiver stalls.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !item_take)
		else $error("result overwritten under stall");

endmodule

FILE: sv/reflow_profile_sequencer.sv
// ----------------------------------------------------------------------------
// reflow_profile_sequencer
// Walks a two-heater oven through a stored profile of up to eight rows.
// ----------------------------------------------------------------------------
// Input beats carry a kind (tick with sample, start, stop) in tuser and a
// signed temperature in tdata. Each accepted beat produces exactly one result
// beat with the heater drives, row number, row-change pulse, finished flag
// and remaining hold ticks.
// Profile rows are written over the cfg channel, index 0 to 7, while the
// block is idle: a rule for the user, not enforced by the block. cfg_ready
// is always high and indexes past 7 are dropped. Each beat passes the input
// register, then the result register. Throughput is one beat per cycle
// without receiver stalls, set by the single state update per item.
// The input register takes a new beat whenever the result register is free
// or is being drained in the same cycle, so a stalled receiver holds one
// result and one waiting beat before s_axis_tready drops.
// Reset clears both registers, loads every row as a finish row, and leaves
// the sequencer finished with both heaters off until a start beat arrives.
// ----------------------------------------------------------------------------
module reflow_profile_sequencer import rps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_DATA_W-1:0]  s_axis_tdata,  // [13:0] temperature, [15:14] zero
	input  logic [KIND_W-1:0]    s_axis_tuser,  // [1:0] kind
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [0] heater_upper, [1] heater_lower, [5:2] step_number, [6] step_changed,
	// [7] finished, [23:8] hold_ticks_left
	output logic [M_DATA_W-1:0]  m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data
);

	logic                     valid_s1;
	kind_t                    kind_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     item_take;
	logic [ROW_SEL_W-1:0]     row_sel;
	row_t                     row;

	assign s_axis_tready = !valid_s1 || item_take;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= kind_t'(s_axis_tuser);
			temp_s1 <= s_axis_tdata[TEMP_W-1:0];
		end
	end

	rps_row_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.rd_sel   (row_sel),
		.rd_row   (row)
	);

	rps_step_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (valid_s1),
		.item_kind     (kind_s1),
		.item_temp     (temp_s1),
		.item_take     (item_take),
		.row_sel       (row_sel),
		.row           (row),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

FILE: tb/tb_reflow_profile_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reflow_profile_sequencer
// Self-checking testbench for the reflow profile sequencer.
// ----------------------------------------------------------------------------
// A queue of sensor beats is filled phase by phase. Later phases load a profile
// over the cfg channel while the block is idle. A clocked driver offers the
// beats with random gaps, and a clocked monitor takes the results with random
// stalls. Every accepted beat runs through a local sequencer model, and each
// result beat is checked field by field against the oldest prediction. The
// stimulus starts with directed rows and ticks. It then runs warm-up ramps
// across random profiles, broken by stray start, stop and unused-kind beats.
// ----------------------------------------------------------------------------
module tb_reflow_profile_sequencer;
	import rps_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;
	localparam int LIMIT_CYCLES = 300000;
	localparam int MAX_REPORTS  = 50;
	localparam int TEMP_MAX     = 8191;
	localparam int TEMP_MIN     = -8192;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_IDX_W'(ROW_REGS + 4);

	typedef struct packed {
		kind_t             kind;
		logic [TEMP_W-1:0] temp;
	} sensor_beat_t;

	// Same layout as m_axis_tdata, last field in the lowest bits.
	typedef struct packed {
		logic [HOLD_W-1:0]    hold_left;
		logic                 finished;
		logic                 changed;
		logic [ROW_IDX_W-1:0] step;
		logic                 lower;
		logic                 upper;
	} seq_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]    s_axis_tuser = KIND_TICK;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROW_W-1:0]     cfg_data = '0;

	reflow_profile_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Model state, kept apart from the block.
	row_t                 profile_rows [ROW_REGS];
	logic [ROW_IDX_W-1:0] seq_row;
	logic [HOLD_W-1:0]    seq_hold;
	logic                 seq_done;
	logic [1:0]           seq_drive;

	sensor_beat_t pending_beats_q[$];
	seq_result_t  expected_outputs_q[$];

	int beats_queued     = 0;
	int beats_predicted  = 0;
	int results_checked  = 0;
	int mismatch_count   = 0;
	int row_advances     = 0;
	int holds_started    = 0;
	int cfg_writes       = 0;
	int profiles_loaded  = 0;
	int cycle_count      = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit pressure_on   = 1'b0;
	int pressure_cnt  = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [1:0] heater_bits(mode_t m);
		return (m inside {MODE_UPPER, MODE_LOWER, MODE_BOTH}) ? m[1:0] : 2'b00;
	endfunction

	// Updates the model state for one accepted beat and returns its result.
	function automatic seq_result_t advance_sequence(kind_t k,
			logic signed [TEMP_W-1:0] temp);
		seq_result_t              res;
		row_t                     row;
		logic signed [TEMP_W-1:0] target;
		logic                     step_pulse;
		step_pulse = 1'b0;
		case (k)
			KIND_START: begin
				seq_row  = '0;
				seq_hold = '0;
				seq_done = 1'b0;
			end
			KIND_STOP: begin
				seq_row   = '0;
				seq_hold  = '0;
				seq_done  = 1'b1;
				seq_drive = 2'b00;
			end
			KIND_TICK: begin
				if (!seq_done) begin
					if (seq_row >= ROW_END) begin
						seq_done  = 1'b1;
						seq_drive = 2'b00;
					end else begin
						row    = profile_rows[seq_row[ROW_SEL_W-1:0]];
						target = row.target;
						if (row.mode == MODE_FINISH) begin
							seq_done  = 1'b1;
							seq_drive = 2'b00;
						end else if (seq_hold != 0) begin
							seq_hold  = seq_hold - 1'b1;
							seq_drive = (temp < target) ? heater_bits(row.mode) : 2'b00;
							if (seq_hold == 0) begin
								seq_row    = seq_row + 1'b1;
								step_pulse = 1'b1;
							end
						end else if (temp < target) begin
							seq_drive = heater_bits(row.mode);
						end else if (temp > target) begin
							if (row.hold == 0) begin
								seq_row    = seq_row + 1'b1;
								step_pulse = 1'b1;
							end else begin
								seq_hold = row.hold;
								holds_started++;
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (step_pulse)
			row_advances++;
		res.upper     = seq_drive[0];
		res.lower     = seq_drive[1];
		res.step      = seq_row;
		res.changed   = step_pulse;
		res.finished  = seq_done;
		res.hold_left = seq_hold;
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			if (mismatch_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic int rand_temp();
		return int'($urandom_range(0, 16383)) + TEMP_MIN;
	endfunction

	function automatic row_t make_row(mode_t m, int tgt, int hold);
		row_t r;
		r.mode   = m;
		r.target = tgt[TEMP_W-1:0];
		r.hold   = hold[HOLD_W-1:0];
		return r;
	endfunction

	// Driver: offers the next pending beat and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin : drive_beats
		sensor_beat_t beat;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= KIND_TICK;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_outputs_q.push_back(advance_sequence(kind_t'(s_axis_tuser),
					s_axis_tdata[TEMP_W-1:0]));
				beats_predicted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_beats_q.size() != 0 &&
						int'($urandom_range(0, 99)) >= send_idle_pct) begin
					beat = pending_beats_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= S_DATA_W'(beat.temp);
					s_axis_tuser  <= beat.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat and paces the receiver side.
	always @(posedge clk or negedge arst_n) begin : check_results
		seq_result_t want;
		seq_result_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_outputs_q.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual %h",
							$time, m_axis_tdata);
					mismatch_count++;
				end else begin
					want = expected_outputs_q.pop_front();
					check_field("heater_upper", want.upper, got.upper);
					check_field("heater_lower", want.lower, got.lower);
					check_field("step_number", want.step, got.step);
					check_field("step_changed", want.changed, got.changed);
					check_field("finished", want.finished, got.finished);
					check_field("hold_ticks_left", want.hold_left, got.hold_left);
					results_checked++;
				end
			end
			if (pressure_on && pressure_cnt < LONG_HOLD) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= int'($urandom_range(0, 99)) >= recv_idle_pct;
			end
		end
	end

	// Counts the cycles of the long receiver hold-off.
	always @(posedge clk) begin : count_pressure
		if (!pressure_on)
			pressure_cnt <= 0;
		else if (pressure_cnt < LONG_HOLD)
			pressure_cnt <= pressure_cnt + 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_outputs_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_beat(kind_t k, int temp);
		sensor_beat_t beat;
		if (temp > TEMP_MAX)
			temp = TEMP_MAX;
		if (temp < TEMP_MIN)
			temp = TEMP_MIN;
		beat.kind = k;
		beat.temp = temp[TEMP_W-1:0];
		pending_beats_q.push_back(beat);
		beats_queued++;
	endtask

	// Runs from a posedge; the caller lowers cfg_valid after the last write.
	task automatic load_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < ROW_REGS)
			profile_rows[idx[ROW_SEL_W-1:0]] = row_t'(value);
		cfg_writes++;
	endtask

	// Waits until every queued beat has been accepted and every result checked.
	task automatic wait_drained();
		do @(negedge clk);
		while (beats_predicted != beats_queued || expected_outputs_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_traffic(int send_pct, int recv_pct, bit pressure);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		pressure_on   = pressure;
	endtask

	task automatic randomize_profile();
		int    tgt;
		mode_t m;
		tgt = rand_temp();
		if (tgt > TEMP_MAX - 100)
			tgt = TEMP_MAX - 100;
		for (int i = 0; i < ROW_REGS; i++) begin
			m = mode_t'($urandom_range(0, 7));
			if (m == MODE_FINISH && $urandom_range(0, 2) != 0)
				m = MODE_BOTH;
			load_row(CFG_IDX_W'(i), make_row(m, tgt,
				($urandom_range(0, 9) < 7) ? 0 : int'($urandom_range(1, 6))));
			tgt += int'($urandom_range(1, 12));
		end
		cfg_valid <= 1'b0;
		profiles_loaded++;
	endtask

	// A start followed by a rising temperature ramp that crosses every target,
	// now and then broken by a stray control beat.
	task automatic queue_warmup_run();
		logic signed [TEMP_W-1:0] t;
		int lo;
		int hi;
		int r;
		int ticks;
		lo = TEMP_MAX;
		hi = TEMP_MIN;
		for (int i = 0; i < ROW_REGS; i++) begin
			t = profile_rows[i].target;
			if (t < lo)
				lo = t;
			if (t > hi)
				hi = t;
		end
		push_beat(KIND_START, rand_temp());
		r = lo - int'($urandom_range(1, 6));
		ticks = 0;
		while (r <= hi + 4 && ticks < 150) begin
			if ($urandom_range(0, 24) == 0)
				push_beat(kind_t'($urandom_range(1, 3)), rand_temp());
			else
				push_beat(KIND_TICK, r + int'($urandom_range(0, 4)) - 2);
			r += int'($urandom_range(0, 3));
			ticks++;
		end
		repeat ($urandom_range(1, 3)) push_beat(KIND_TICK, rand_temp());
	endtask

	task automatic queue_noise();
		repeat ($urandom_range(1, 5)) push_beat(kind_t'($urandom_range(0, 3)), rand_temp());
	endtask

	task automatic queue_random(int count);
		int stop_at;
		stop_at = beats_queued + count;
		while (beats_queued < stop_at) begin
			if ($urandom_range(0, 9) < 8)
				queue_warmup_run();
			else
				queue_noise();
		end
	endtask

	initial begin : sequence_phases
		for (int i = 0; i < ROW_REGS; i++)
			profile_rows[i] = ROW_RESET;
		seq_row   = '0;
		seq_hold  = '0;
		seq_done  = 1'b1;
		seq_drive = 2'b00;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset profile: every row is a finish row.
		@(negedge clk);
		push_beat(KIND_TICK, 0);
		push_beat(KIND_START, TEMP_MAX);
		push_beat(KIND_TICK, TEMP_MIN);
		push_beat(KIND_NONE, TEMP_MAX);
		push_beat(KIND_TICK, 5);
		push_beat(KIND_STOP, TEMP_MIN);
		wait_drained();

		// Directed profile that walks every mode but finish and ends past the table.
		load_row(0, make_row(MODE_UPPER, TEMP_MIN, 0));
		load_row(1, make_row(MODE_LOWER, 100, 3));
		load_row(2, make_row(MODE_RSVD5, 0, 0));
		load_row(3, make_row(MODE_BOTH, 10, 0));
		load_row(4, make_row(MODE_OFF, 20, 1));
		load_row(5, make_row(MODE_RSVD6, 30, 0));
		load_row(6, make_row(MODE_RSVD7, 40, 0));
		load_row(7, make_row(MODE_BOTH, 50, 0));
		cfg_valid <= 1'b0;
		profiles_loaded++;
		@(negedge clk);
		push_beat(KIND_START, 0);
		push_beat(KIND_TICK, TEMP_MIN);      // equal to target, nothing moves
		push_beat(KIND_TICK, TEMP_MIN + 1);  // above with no hold, advance
		push_beat(KIND_TICK, 50);            // lower heater on
		push_beat(KIND_START, 0);            // drive kept until the next tick
		push_beat(KIND_TICK, TEMP_MIN + 1);
		push_beat(KIND_TICK, 100);
		push_beat(KIND_TICK, 101);           // hold loaded, drive kept
		push_beat(KIND_TICK, 99);
		push_beat(KIND_TICK, 200);
		push_beat(KIND_TICK, 0);             // hold runs out, advance
		push_beat(KIND_TICK, -1);
		push_beat(KIND_TICK, 1);
		push_beat(KIND_TICK, 5);
		push_beat(KIND_TICK, 11);
		push_beat(KIND_TICK, 21);
		push_beat(KIND_TICK, 21);
		push_beat(KIND_TICK, 31);
		push_beat(KIND_TICK, 41);
		push_beat(KIND_TICK, 0);
		push_beat(KIND_TICK, 51);
		push_beat(KIND_TICK, 0);             // past the table, run ends
		push_beat(KIND_TICK, TEMP_MAX);      // ignored after the end
		push_beat(KIND_NONE, 0);
		push_beat(KIND_STOP, 0);
		wait_drained();

		// Register extremes; the write to an unused index must change nothing.
		load_row(0, {ROW_W{1'b1}});
		for (int i = 1; i < ROW_REGS; i++)
			load_row(CFG_IDX_W'(i), '0);
		load_row(CFG_IDX_UNUSED, {ROW_W{1'b1}});
		cfg_valid <= 1'b0;
		profiles_loaded++;
		@(negedge clk);
		push_beat(KIND_START, 0);
		push_beat(KIND_TICK, TEMP_MAX);      // longest hold loaded
		push_beat(KIND_TICK, TEMP_MIN);
		push_beat(KIND_TICK, 0);
		push_beat(KIND_START, 0);
		push_beat(KIND_TICK, -1);
		push_beat(KIND_TICK, -2);
		push_beat(KIND_STOP, 0);
		queue_random(50);
		wait_drained();

		randomize_profile();
		set_traffic(0, 0, 1'b0);
		queue_random(160);
		wait_drained();

		randomize_profile();
		set_traffic(73, 0, 1'b0);
		queue_random(160);
		wait_drained();

		randomize_profile();
		set_traffic(0, 73, 1'b0);
		queue_random(160);
		wait_drained();

		randomize_profile();
		set_traffic(13, 13, 1'b0);
		queue_random(160);
		wait_drained();

		// The receiver holds off while the sender keeps offering beats.
		randomize_profile();
		set_traffic(0, 0, 1'b1);
		queue_random(160);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d input beats across %0d profiles (%0d writes).",
			results_checked, beats_predicted, profiles_loaded, cfg_writes);
		$display("The model saw %0d row advances and %0d holds started.",
			row_advances, holds_started);
		if (mismatch_count == 0 && expected_outputs_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/rps_pkg.sv
sv/rps_row_table.sv
sv/rps_step_core.sv
sv/reflow_profile_sequencer.sv
tb/tb_reflow_profile_sequencer.sv
